// ----- hw/rtl/mi3_pkg.sv -----
package mi3_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAT_N = 9;

    // Derived widths of the datapath
    localparam int PROD_W = 2 * WORD_BITS;
    localparam int COF_W = 2 * WORD_BITS + 1;
    localparam int CMAG_W = 2 * WORD_BITS;
    localparam int TERM_W = 3 * WORD_BITS + 1;
    localparam int DET_W = 3 * WORD_BITS + 3;
    localparam int DMAG_W = 3 * WORD_BITS;
    localparam int SHIFT = 2 * FRAC_BITS;
    localparam int NFULL_W = CMAG_W + SHIFT;
    localparam int NHI_W = NFULL_W - WORD_BITS;
    localparam int CMP_W = (NHI_W > DMAG_W) ? NHI_W : DMAG_W;

    // Register stages of the cofactor/determinant front end
    localparam int FRONT_DEPTH = 7;
    // Stages from input to the last lane register (output register excluded)
    localparam int PIPE_DEPTH = FRONT_DEPTH + WORD_BITS + 1;

    // Cofactor k = a[P]*a[Q] - a[S]*a[T], entries in row-major order
    localparam int unsigned COF_P [MAT_N] = '{4, 7, 1, 5, 0, 3, 3, 6, 0};
    localparam int unsigned COF_Q [MAT_N] = '{8, 2, 5, 6, 8, 2, 7, 1, 4};
    localparam int unsigned COF_S [MAT_N] = '{7, 1, 2, 3, 6, 0, 4, 0, 1};
    localparam int unsigned COF_T [MAT_N] = '{5, 8, 4, 8, 2, 5, 6, 7, 3};

    typedef struct packed {
        logic signed [WORD_BITS-1:0] a00;
        logic signed [WORD_BITS-1:0] a01;
        logic signed [WORD_BITS-1:0] a02;
        logic signed [WORD_BITS-1:0] a10;
        logic signed [WORD_BITS-1:0] a11;
        logic signed [WORD_BITS-1:0] a12;
        logic signed [WORD_BITS-1:0] a20;
        logic signed [WORD_BITS-1:0] a21;
        logic signed [WORD_BITS-1:0] a22;
    } mat_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] r00;
        logic signed [WORD_BITS-1:0] r01;
        logic signed [WORD_BITS-1:0] r02;
        logic signed [WORD_BITS-1:0] r10;
        logic signed [WORD_BITS-1:0] r11;
        logic signed [WORD_BITS-1:0] r12;
        logic signed [WORD_BITS-1:0] r20;
        logic signed [WORD_BITS-1:0] r21;
        logic signed [WORD_BITS-1:0] r22;
        logic                        singular;
    } inv_t;

    // Start of one divider lane
    typedef struct packed {
        logic                  ovf;
        logic                  neg;
        logic [WORD_BITS-1:0]  nlow;
        logic [DMAG_W-1:0]     rem;
    } lane_t;

endpackage

// ----- hw/rtl/mi3_front.sv -----
module mi3_front
    import mi3_pkg::*;
(
    input  logic              clk,
    input  logic              adv,
    input  mat_t              mat,
    output lane_t             lanes [MAT_N],
    output logic [DMAG_W-1:0] dmag,
    output logic              singular
);

    logic signed [WORD_BITS-1:0] a [MAT_N];

    logic signed [PROD_W-1:0]    pq_reg [MAT_N];
    logic signed [PROD_W-1:0]    st_reg [MAT_N];
    logic signed [WORD_BITS-1:0] col1_reg [3];
    logic signed [COF_W-1:0]     c2_reg [MAT_N];
    logic signed [WORD_BITS-1:0] col2_reg [3];
    logic signed [2*WORD_BITS:0] lo_reg [3];
    logic signed [2*WORD_BITS:0] hi_reg [3];
    logic signed [COF_W-1:0]     c3_reg [MAT_N];
    logic signed [TERM_W-1:0]    term_reg [3];
    logic signed [COF_W-1:0]     c4_reg [MAT_N];
    logic signed [DET_W-1:0]     det_reg;
    logic signed [COF_W-1:0]     c5_reg [MAT_N];
    logic [DMAG_W-1:0]           dmag6_reg;
    logic                        sing6_reg;
    logic [CMAG_W-1:0]           cmag6_reg [MAT_N];
    logic                        neg6_reg [MAT_N];
    lane_t                       lanes_reg [MAT_N];
    logic [DMAG_W-1:0]           dmag7_reg;
    logic                        sing7_reg;

    logic [DET_W-1:0]            det_abs;
    logic [COF_W-1:0]            c_abs [MAT_N];
    logic [NFULL_W-1:0]          nfull [MAT_N];

    always_comb
    begin
        a[0] = mat.a00;
        a[1] = mat.a01;
        a[2] = mat.a02;
        a[3] = mat.a10;
        a[4] = mat.a11;
        a[5] = mat.a12;
        a[6] = mat.a20;
        a[7] = mat.a21;
        a[8] = mat.a22;
    end

    always_comb
    begin
        det_abs = det_reg[DET_W-1] ? -det_reg : det_reg;
        for (int k = 0; k < MAT_N; k++)
        begin
            c_abs[k] = c5_reg[k][COF_W-1] ? -c5_reg[k] : c5_reg[k];
            nfull[k] = {cmag6_reg[k], {SHIFT{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // products of the cofactors
            for (int k = 0; k < MAT_N; k++)
            begin
                pq_reg[k] <= a[COF_P[k]] * a[COF_Q[k]];
                st_reg[k] <= a[COF_S[k]] * a[COF_T[k]];
            end
            col1_reg[0] <= a[0];
            col1_reg[1] <= a[3];
            col1_reg[2] <= a[6];

            for (int k = 0; k < MAT_N; k++)
            begin
                c2_reg[k] <= COF_W'(pq_reg[k]) - COF_W'(st_reg[k]);
            end
            col2_reg <= col1_reg;

            // split the wide cofactor into two narrow partial products
            for (int j = 0; j < 3; j++)
            begin
                lo_reg[j] <= $signed({1'b0, c2_reg[j][WORD_BITS-1:0]}) * col2_reg[j];
                hi_reg[j] <= $signed(c2_reg[j][COF_W-1:WORD_BITS]) * col2_reg[j];
            end
            c3_reg <= c2_reg;

            for (int j = 0; j < 3; j++)
            begin
                term_reg[j] <= (TERM_W'(hi_reg[j]) <<< WORD_BITS) + TERM_W'(lo_reg[j]);
            end
            c4_reg <= c3_reg;

            det_reg <= DET_W'(term_reg[0]) + DET_W'(term_reg[1]) + DET_W'(term_reg[2]);
            c5_reg <= c4_reg;

            dmag6_reg <= DMAG_W'(det_abs);
            sing6_reg <= (det_reg == '0);
            for (int k = 0; k < MAT_N; k++)
            begin
                cmag6_reg[k] <= CMAG_W'(c_abs[k]);
                neg6_reg[k]  <= c5_reg[k][COF_W-1] ^ det_reg[DET_W-1];
            end

            // quotient too large for the word: saturate later
            for (int k = 0; k < MAT_N; k++)
            begin
                lanes_reg[k].ovf  <= CMP_W'(nfull[k][NFULL_W-1:WORD_BITS]) >= CMP_W'(dmag6_reg);
                lanes_reg[k].neg  <= neg6_reg[k];
                lanes_reg[k].nlow <= nfull[k][WORD_BITS-1:0];
                lanes_reg[k].rem  <= DMAG_W'(nfull[k][NFULL_W-1:WORD_BITS]);
            end
            dmag7_reg <= dmag6_reg;
            sing7_reg <= sing6_reg;
        end
    end

    assign lanes    = lanes_reg;
    assign dmag     = dmag7_reg;
    assign singular = sing7_reg;

endmodule

// ----- hw/rtl/mi3_lane.sv -----
module mi3_lane
    import mi3_pkg::*;
(
    input  logic                               clk,
    input  logic                               adv,
    input  lane_t                              src,
    input  logic [WORD_BITS:0][DMAG_W-1:0]     dmag,
    output logic signed [WORD_BITS-1:0]        res
);

    localparam logic [WORD_BITS:0] LIM = (WORD_BITS+1)'(1) << (WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [DMAG_W-1:0]    rem_reg  [WORD_BITS];
    logic [WORD_BITS-1:0] q_reg    [WORD_BITS];
    logic [WORD_BITS-1:0] nlow_reg [WORD_BITS];
    logic [WORD_BITS-1:0] ovf_reg;
    logic [WORD_BITS-1:0] neg_reg;

    logic [WORD_BITS:0]   qr_reg;
    logic                 ovf_r_reg;
    logic                 neg_r_reg;
    logic                 round_up;

    for (genvar k = 0; k < WORD_BITS; k++)
    begin : g_step
        logic [DMAG_W-1:0]    rem_in;
        logic [WORD_BITS-1:0] q_in;
        logic [WORD_BITS-1:0] nl_in;
        logic                 ovf_in;
        logic                 neg_in;
        logic [DMAG_W:0]      rem2;
        logic [DMAG_W:0]      dx;

        if (k == 0)
        begin : g_first
            assign rem_in = src.rem;
            assign q_in   = '0;
            assign nl_in  = src.nlow;
            assign ovf_in = src.ovf;
            assign neg_in = src.neg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign nl_in  = nlow_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        assign rem2 = {rem_in, nl_in[WORD_BITS-1]};
        assign dx   = {1'b0, dmag[k]};

        // one restoring step: compare, subtract, shift in a quotient bit
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rem2 >= dx)
                begin
                    rem_reg[k] <= DMAG_W'(rem2 - dx);
                    q_reg[k]   <= {q_in[WORD_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= DMAG_W'(rem2);
                    q_reg[k]   <= {q_in[WORD_BITS-2:0], 1'b0};
                end
                nlow_reg[k] <= {nl_in[WORD_BITS-2:0], 1'b0};
                ovf_reg[k]  <= ovf_in;
                neg_reg[k]  <= neg_in;
            end
        end
    end

    // round half away from zero on the magnitude
    assign round_up = {rem_reg[WORD_BITS-1], 1'b0} >= {1'b0, dmag[WORD_BITS]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qr_reg    <= {1'b0, q_reg[WORD_BITS-1]} + (WORD_BITS+1)'(round_up);
            ovf_r_reg <= ovf_reg[WORD_BITS-1];
            neg_r_reg <= neg_reg[WORD_BITS-1];
        end
    end

    always_comb
    begin
        priority if (ovf_r_reg && !neg_r_reg)
            res = MAX_POS;
        else if (ovf_r_reg)
            res = MIN_NEG;
        else if (!neg_r_reg && qr_reg >= LIM)
            res = MAX_POS;
        else if (neg_r_reg && qr_reg > LIM)
            res = MIN_NEG;
        else if (neg_r_reg)
            res = WORD_BITS'(~qr_reg + (WORD_BITS+1)'(1));
        else
            res = WORD_BITS'(qr_reg);
    end

endmodule

// ----- hw/rtl/matrix_inverse_3x3_top.sv -----
// 3x3 matrix inverse, signed Q16.16, adjugate over determinant.
// Path: the cofactor/determinant front end, then the bit-per-stage divider lanes
//   and their rounding register, then the output register.
// Throughput: one matrix per cycle; a stalled output freezes the whole pipe.
// Reset: rst_n low clears every valid bit and the output valid; data
//   registers are not reset.
module matrix_inverse_3x3_top
    import mi3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic mat_valid,
    output logic mat_stall,
    input  mat_t mat,
    output logic inv_valid,
    input  logic inv_stall,
    output inv_t inv
);

    // Whole pipe advances unless a finished beat sits in the output
    // register and the sink holds it off.
    logic adv;

    // Valid bits that travel alongside the data stages
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    // Front end outputs: one divider start per entry, shared divisor
    lane_t             lanes [MAT_N];
    logic [DMAG_W-1:0] front_dmag;
    logic              front_sing;

    // Divisor copies, one per divider stage, plus the rounding stage
    logic [WORD_BITS-1:0][DMAG_W-1:0] dmag_reg;
    logic [WORD_BITS:0][DMAG_W-1:0]   dmag_taps;

    // Singular flag follows the divider lanes
    logic [WORD_BITS:0] sing_reg;

    logic signed [WORD_BITS-1:0] res [MAT_N];

    logic inv_valid_reg;
    logic inv_valid_next;
    inv_t inv_reg;
    inv_t inv_next;

    assign adv       = !(inv_valid_reg && inv_stall);
    assign mat_stall = !adv;

    mi3_front u_front (
        .clk      (clk),
        .adv      (adv),
        .mat      (mat),
        .lanes    (lanes),
        .dmag     (front_dmag),
        .singular (front_sing)
    );

    assign dmag_taps = {dmag_reg, front_dmag};

    for (genvar k = 0; k < MAT_N; k++)
    begin : g_lane
        mi3_lane u_lane (
            .clk  (clk),
            .adv  (adv),
            .src  (lanes[k]),
            .dmag (dmag_taps),
            .res  (res[k])
        );
    end

    // Hold the divisor and flag in step with the lanes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmag_reg <= {dmag_reg[WORD_BITS-2:0], front_dmag};
            sing_reg <= {sing_reg[WORD_BITS-1:0], front_sing};
        end
    end

    // A beat enters whenever the pipe advances with mat_valid high
    assign vld_next = adv ? {vld_reg[PIPE_DEPTH-2:0], mat_valid} : vld_reg;

    always_comb
    begin
        inv_valid_next = inv_valid_reg;
        inv_next       = inv_reg;
        if (adv)
        begin
            inv_valid_next = vld_reg[PIPE_DEPTH-1];
            // Singular matrix: drop the lane results, report zeros
            if (sing_reg[WORD_BITS])
            begin
                inv_next          = '0;
                inv_next.singular = 1'b1;
            end
            else
            begin
                inv_next.r00      = res[0];
                inv_next.r01      = res[1];
                inv_next.r02      = res[2];
                inv_next.r10      = res[3];
                inv_next.r11      = res[4];
                inv_next.r12      = res[5];
                inv_next.r20      = res[6];
                inv_next.r21      = res[7];
                inv_next.r22      = res[8];
                inv_next.singular = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            inv_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            inv_valid_reg <= inv_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inv_reg <= inv_next;
    end

    assign inv_valid = inv_valid_reg;
    assign inv       = inv_reg;

endmodule

// ----- hw/rtl/mi3_chk.sv -----
module mi3_chk
    import mi3_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic mat_valid,
    input logic mat_stall,
    input mat_t mat,
    input logic inv_valid,
    input logic inv_stall,
    input inv_t inv
);

    // hold an offered matrix beat until it is taken
    a_mat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && mat_stall |=> mat_valid && $stable(mat))
        else $error("matrix beat changed while stalled");

    // hold a stalled result beat
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_stall |=> inv_valid)
        else $error("result beat dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_stall |=> $stable(inv))
        else $error("result beat changed while stalled");

    // input backpressure only comes from a held result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        mat_stall |-> (inv_valid && inv_stall))
        else $error("input stalled without output backpressure");

    // singular result carries zero entries
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv.singular |->
            inv.r00 == '0 && inv.r01 == '0 && inv.r02 == '0 &&
            inv.r10 == '0 && inv.r11 == '0 && inv.r12 == '0 &&
            inv.r20 == '0 && inv.r21 == '0 && inv.r22 == '0)
        else $error("singular result with nonzero entry");

endmodule

bind matrix_inverse_3x3_top mi3_chk u_mi3_chk (.*);

// ----- test/matrix_inverse_3x3_top_tb.sv -----
`timescale 1ns / 100ps

module matrix_inverse_3x3_top_tb;

    import mi3_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam logic signed [31:0] ONE    = 32'sh0001_0000;
    localparam logic signed [31:0] MAXW   = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINW   = 32'sh8000_0000;
    localparam int                 RANDOM_ITEMS = 1230;
    localparam int                 QUIET_TAIL   = 200;
    localparam int                 DRAIN_CYCLES = 60;
    localparam int                 CYCLE_LIMIT  = 400000;
    localparam int                 HOLD_CYCLES  = 400;

    // Scoreboard: predicts the inverse of each accepted matrix and checks results in order.
    class inverse_scoreboard;
        inv_t inverse_q[$];
        int   errors;
        int   results_seen;
        int   singular_seen;

        function new();
            errors = 0;
            results_seen = 0;
            singular_seen = 0;
        endfunction

        task report(input string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // round(c * 2^32 / d), ties away from zero, saturated to a word
        function logic [31:0] scaled_quotient(input wide_t c, input wide_t d);
            logic [255:0] cm;
            logic [255:0] dm;
            logic [255:0] q;
            logic [255:0] r;
            bit           neg;
            neg = (c < 0) != (d < 0);
            cm = (c < 0) ? -c : c;
            cm = cm << (2 * FRAC_BITS);
            dm = (d < 0) ? -d : d;
            q = cm / dm;
            r = cm % dm;
            if ((r << 1) >= dm)
                q = q + 1;
            if (!neg && q >= 256'h8000_0000)
                return MAXW;
            if (neg && q > 256'h8000_0000)
                return MINW;
            return neg ? -q[31:0] : q[31:0];
        endfunction

        function inv_t invert(input mat_t m);
            int unsigned pa [9] = '{4, 7, 1, 5, 0, 3, 3, 6, 0};
            int unsigned qa [9] = '{8, 2, 5, 6, 8, 2, 7, 1, 4};
            int unsigned sa [9] = '{7, 1, 2, 3, 6, 0, 4, 0, 1};
            int unsigned ta [9] = '{5, 8, 4, 8, 2, 5, 6, 7, 3};
            logic [9*WORD_BITS-1:0] mv;
            logic [9*WORD_BITS:0]   rv;
            wide_t                  e [9];
            wide_t                  cof [9];
            wide_t                  det;
            inv_t                   res;
            mv = m;
            for (int k = 0; k < 9; k++)
                e[k] = wide_t'($signed(mv[9*WORD_BITS-1-WORD_BITS*k -: WORD_BITS]));
            for (int k = 0; k < 9; k++)
                cof[k] = e[pa[k]] * e[qa[k]] - e[sa[k]] * e[ta[k]];
            // expand along the first column
            det = cof[0] * e[0] + cof[1] * e[3] + cof[2] * e[6];
            rv = '0;
            if (det == 0)
                rv[0] = 1'b1;
            else
                for (int k = 0; k < 9; k++)
                    rv[9*WORD_BITS-WORD_BITS*k -: WORD_BITS] = scaled_quotient(cof[k], det);
            res = rv;
            return res;
        endfunction

        function void note(input mat_t m);
            inverse_q.push_back(invert(m));
        endfunction

        task check(input inv_t got);
            inv_t                 want;
            logic [9*WORD_BITS:0] gv;
            logic [9*WORD_BITS:0] wv;
            string                names [9] = '{"r00", "r01", "r02", "r10", "r11", "r12",
                                                "r20", "r21", "r22"};
            results_seen++;
            if (inverse_q.size() == 0)
            begin
                report("result beat with no matrix outstanding");
                return;
            end
            want = inverse_q.pop_front();
            gv = got;
            wv = want;
            if (want.singular)
                singular_seen++;
            for (int k = 0; k < 9; k++)
                if (gv[9*WORD_BITS-WORD_BITS*k -: WORD_BITS]
                        !== wv[9*WORD_BITS-WORD_BITS*k -: WORD_BITS])
                    report($sformatf("%s got %h want %h", names[k],
                        gv[9*WORD_BITS-WORD_BITS*k -: WORD_BITS],
                        wv[9*WORD_BITS-WORD_BITS*k -: WORD_BITS]));
            if (gv[0] !== wv[0])
                report($sformatf("singular got %b want %b", gv[0], wv[0]));
        endtask

        function int pending();
            return inverse_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic mat_valid;
    logic mat_stall;
    mat_t mat;
    logic inv_valid;
    logic inv_stall;
    inv_t inv;

    inverse_scoreboard sb;
    int  cycles;
    int  sent;
    bit  quiet;      // no idling on either side in the last part of the run
    bit  hold_req;   // ask the receiver for one long hold-off

    matrix_inverse_3x3_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .mat       (mat),
        .inv_valid (inv_valid),
        .inv_stall (inv_stall),
        .inv       (inv)
    );

    always #5 clk = ~clk;

    // Watchdog: end the run if it goes far past any correct finishing time.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d matrices outstanding", cycles, sb.pending());
            $display("FAIL matrix_inverse_3x3_top");
            $finish;
        end
    end

    // Check every result beat: one accepted when valid is high and stall low at the edge.
    always @(posedge clk)
    begin
        if (rst_n && inv_valid && !inv_stall)
            sb.check(inv);
    end

    // Result-side stall: random bursts, plus one long hold-off on request.
    initial
    begin
        inv_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // hold off long enough to fill the pipe and push back on the input
                inv_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                inv_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                inv_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                inv_stall <= 1'b0;
            end
        end
    end

    function automatic mat_t mk(input logic signed [31:0] x0, x1, x2, x3, x4, x5, x6, x7, x8);
        mat_t m;
        m = {x0, x1, x2, x3, x4, x5, x6, x7, x8};
        return m;
    endfunction

    // Offer one matrix beat; hold it until taken, then note the expected inverse.
    task send(input mat_t m);
        mat_valid <= 1'b1;
        mat <= m;
        @(posedge clk);
        while (mat_stall)
            @(posedge clk);
        sb.note(m);
        sent++;
    endtask

    // Drop valid for a random burst now and then.
    task maybe_idle();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            mat_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] small_entry();
        return $signed($urandom_range(0, 8 * 65536)) - 32'sd262144;
    endfunction

    function automatic logic signed [31:0] corner_entry();
        logic signed [31:0] picks [8] = '{MAXW, MINW, 32'sd0, 32'sd1, -32'sd1, ONE, -ONE,
                                           32'sh0000_8000};
        return picks[$urandom_range(0, 7)];
    endfunction

    function automatic mat_t random_matrix();
        logic signed [31:0] x [9];
        int                 kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
            case (1'b1)
                kind < 4: x[k] = $urandom();
                kind < 8: x[k] = small_entry();
                default:  x[k] = corner_entry();
            endcase
        // make some of them singular: repeat a row or a column
        if ($urandom_range(0, 9) == 0)
        begin
            x[6] = x[0];
            x[7] = x[1];
            x[8] = x[2];
        end
        else if ($urandom_range(0, 14) == 0)
        begin
            x[1] = x[0];
            x[4] = x[3];
            x[7] = x[6];
        end
        return mk(x[0], x[1], x[2], x[3], x[4], x[5], x[6], x[7], x[8]);
    endfunction

    initial
    begin
        mat_t directed [$];
        clk = 1'b0;
        rst_n = 1'b0;
        mat_valid = 1'b0;
        mat = '0;
        cycles = 0;
        sent = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        sb = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity and scalings, singular cases, saturation and rounding.
        directed.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        directed.push_back(mk(2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE));
        directed.push_back(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
        directed.push_back(mk(3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE));
        directed.push_back(mk(-3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, ONE));
        directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        directed.push_back(mk(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW));
        directed.push_back(mk(MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW));
        directed.push_back(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(mk(-1, 0, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(mk(MAXW, 0, 0, 0, MAXW, 0, 0, 0, MAXW));
        directed.push_back(mk(MINW, 0, 0, 0, MINW, 0, 0, 0, MINW));
        directed.push_back(mk(MAXW, MINW, 0, 0, MAXW, MINW, MINW, 0, MAXW));
        directed.push_back(mk(MINW, MAXW, 1, -1, MINW, MAXW, MAXW, 1, MINW));
        directed.push_back(mk(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
        directed.push_back(mk(0, 0, ONE, 0, ONE, 0, ONE, 0, 0));
        directed.push_back(mk(ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, 0));
        directed.push_back(mk(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                              7 * ONE, 8 * ONE, 9 * ONE));
        directed.push_back(mk(32'sh0000_8000, 0, 0, 0, 32'sh0000_8000, 0, 0, 0, ONE));
        directed.push_back(mk(7, 0, 0, 0, 7, 0, 0, 0, 7));
        foreach (directed[i])
        begin
            send(directed[i]);
            maybe_idle();
        end

        // Random matrices, with one long result hold-off and one full drain along the way.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 300)
                hold_req = 1'b1;
            if (i == 700)
            begin
                // pause the input until every outstanding inverse has come back
                mat_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            send(random_matrix());
            maybe_idle();
        end
        mat_valid <= 1'b0;

        // Drain, then give the pipe time to show any stray result beat.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d matrices, checked %0d inverses (%0d singular), %0d mismatches",
                 sent, sb.results_seen, sb.singular_seen, sb.errors);
        $display("covered identity, saturation, rounding, singular and random Q16.16 inputs");
        if (sb.errors == 0)
            $display("PASS matrix_inverse_3x3_top");
        else
            $display("FAIL matrix_inverse_3x3_top");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_front.sv
hw/rtl/mi3_lane.sv
hw/rtl/matrix_inverse_3x3_top.sv
hw/rtl/mi3_chk.sv
test/matrix_inverse_3x3_top_tb.sv
